/* design/gfa_pkg.sv */
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared types and constants for the growable free-list slot allocator.
// ----------------------------------------------------------------------------
package gfa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int TAG_WIDTH  = 32;
  localparam int REG_W      = 11;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // null link: one past the last slot
  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(POOL_DEPTH);

  localparam logic [REG_W-1:0] POOL_MAX_RST  = REG_W'(1000);
  localparam logic [REG_W-1:0] GROW_STEP_RST = REG_W'(0);

  // register index, taken from paddr[2]
  localparam logic REG_POOL_MAX  = 1'b0;
  localparam logic REG_GROW_STEP = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_ALLOC = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FREED = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } gfa_state_t;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_W-1:0]    entry_index;
    logic [TAG_WIDTH-1:0] callback_tag;
    logic                 callback_present;
  } gfa_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SLOT_W-1:0]    slot_index;
    logic [TAG_WIDTH-1:0] release_tag;
    logic                 release_fire;
    logic [CNT_W-1:0]     slots_created;
  } gfa_out_t;

endpackage

/* design/growable_free_list_allocator_core.sv */
// ----------------------------------------------------------------------------
// growable_free_list_allocator_core
// LIFO free list of request slots with lazy growth; link and tag RAMs.
//
//   channel  dir  signals                                   payload
//   in       in   in_valid / in_ready                       gfa_in_t
//   out      out  out_valid / out_ready                     gfa_out_t
//   cfg      in   psel penable pwrite paddr pwdata prdata   pool_max, grow_step
//
// Each item is handled in ST_IDLE, which issues the link/tag RAM reads as it
// is accepted, then in ST_EXEC, which updates head and writes back. The next
// item is accepted while a result still sits in the output register; only a
// full output register stalls. Reset is synchronous and needs no clearing pass:
// a new block is linked implicitly (ascending run from fresh_lo_r below created_r).
// ----------------------------------------------------------------------------
module growable_free_list_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gfa_pkg::gfa_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gfa_pkg::gfa_out_t                 out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gfa_pkg::APB_AW-1:0]        paddr,
  input  logic [gfa_pkg::APB_DW-1:0]        pwdata,
  output logic [gfa_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import gfa_pkg::*;

  gfa_state_t       state_r, state_nxt;
  gfa_in_t          item_r;
  gfa_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] created_r, created_nxt;
  logic [CNT_W-1:0] fresh_lo_r, fresh_lo_nxt;
  logic [REG_W-1:0] pool_max_r, grow_step_r;

  logic [CNT_W-1:0]     link_rd;
  logic [TAG_WIDTH:0]   tag_rd;
  logic                 link_we, tag_we;
  logic [SLOT_W-1:0]    tag_raddr, tag_waddr;

  logic             accept, exec_go;
  logic [CNT_W-1:0] eff_max, remaining, grow_n, head_inc;
  logic             fresh_hit, idx_ok;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_max_r  <= POOL_MAX_RST;
      grow_step_r <= GROW_STEP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_POOL_MAX:  pool_max_r  <= pwdata[REG_W-1:0];
        REG_GROW_STEP: grow_step_r <= pwdata[REG_W-1:0];
        default:       pool_max_r  <= pool_max_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_GROW_STEP) ? APB_DW'(grow_step_r) : APB_DW'(pool_max_r);

  // ---------------- memories ----------------
  assign tag_raddr = (state_r == ST_IDLE) ? in_data.entry_index : item_r.entry_index;

  gfa_ram #(.WIDTH(CNT_W), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (item_r.entry_index),
    .wdata (head_r),
    .raddr (head_r[SLOT_W-1:0]),
    .rdata (link_rd)
  );

  gfa_ram #(.WIDTH(TAG_WIDTH + 1), .DEPTH(POOL_DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata ({item_r.callback_present, item_r.callback_tag}),
    .raddr (tag_raddr),
    .rdata (tag_rd)
  );

  // ---------------- datapath ----------------
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign eff_max   = (pool_max_r > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : pool_max_r;
  assign remaining = eff_max - created_r;
  assign grow_n    = (grow_step_r != '0 && grow_step_r < remaining) ? grow_step_r : remaining;
  assign head_inc  = head_r + CNT_W'(1);
  // head sits at the start of the implicitly linked run of the newest block
  assign fresh_hit = (head_r == fresh_lo_r) && (fresh_lo_r < created_r);
  assign idx_ok    = {1'b0, item_r.entry_index} < created_r;

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    head_nxt      = head_r;
    created_nxt   = created_r;
    fresh_lo_nxt  = fresh_lo_r;
    link_we       = 1'b0;
    tag_we        = 1'b0;
    tag_waddr     = head_r[SLOT_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt.release_tag  = '0;
          out_nxt.release_fire = 1'b0;
          if (item_r.kind == KIND_ALLOC) begin
            if (head_r == NULL_LINK) begin
              if (created_r < eff_max) begin
                // grow a block and pop its first slot in one go
                tag_we         = 1'b1;
                tag_waddr      = created_r[SLOT_W-1:0];
                out_nxt.status = STAT_ALLOC;
                out_nxt.slot_index = created_r[SLOT_W-1:0];
                fresh_lo_nxt   = created_r + CNT_W'(1);
                created_nxt    = created_r + grow_n;
                head_nxt       = (grow_n == CNT_W'(1)) ? NULL_LINK : created_r + CNT_W'(1);
              end else begin
                out_nxt.status     = STAT_EMPTY;
                out_nxt.slot_index = '0;
              end
            end else begin
              tag_we             = 1'b1;
              out_nxt.status     = STAT_ALLOC;
              out_nxt.slot_index = head_r[SLOT_W-1:0];
              if (fresh_hit) begin
                fresh_lo_nxt = head_inc;
                head_nxt     = (head_inc < created_r) ? head_inc : NULL_LINK;
              end else begin
                head_nxt = link_rd;
              end
            end
          end else begin
            out_nxt.status     = STAT_FREED;
            out_nxt.slot_index = item_r.entry_index;
            if (idx_ok) begin
              link_we              = 1'b1;
              head_nxt             = {1'b0, item_r.entry_index};
              out_nxt.release_tag  = tag_rd[TAG_WIDTH-1:0];
              out_nxt.release_fire = tag_rd[TAG_WIDTH];
            end
          end
          out_nxt.slots_created = created_nxt;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= NULL_LINK;
      created_r   <= '0;
      fresh_lo_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      created_r   <= created_nxt;
      fresh_lo_r  <= fresh_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/gfa_ram.sv */
// ----------------------------------------------------------------------------
// gfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
